>>> hw/rtl/uehr_pkg.sv
// Shared types, constants and the header rewrite map of the UDP echo header rewriter.
package uehr_pkg;

    localparam int unsigned ADDR_W = 6;
    localparam int unsigned HDR_DEPTH = 46;

    // Frame handling modes
    localparam logic [1:0] MODE_COLLECT = 2'd0;
    localparam logic [1:0] MODE_PASS    = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    // Source of one rewritten header byte
    localparam logic [1:0] SEL_STORE   = 2'd0;
    localparam logic [1:0] SEL_ZERO    = 2'd1;
    localparam logic [1:0] SEL_CSUM_HI = 2'd2;
    localparam logic [1:0] SEL_CSUM_LO = 2'd3;

    // Header geometry (byte positions)
    localparam logic [ADDR_W-1:0] L2_PLAIN      = 6'd14;
    localparam logic [ADDR_W-1:0] L2_VLAN       = 6'd18;
    localparam logic [ADDR_W-1:0] IP_LEN        = 6'd20;
    localparam logic [ADDR_W-1:0] HDR_END_PLAIN = 6'd41;
    localparam logic [ADDR_W-1:0] HDR_END_VLAN  = 6'd45;
    localparam logic [ADDR_W-1:0] ETYPE_LO_POS  = 6'd13;
    localparam logic [ADDR_W-1:0] INNER_LO_POS  = 6'd17;
    localparam logic [ADDR_W-1:0] PROTO_OFS     = 6'd9;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        sel;
    } t_map;

    // Map an output header index to the stored byte it comes from
    function automatic t_map hdr_map(input logic [ADDR_W-1:0] idx, input logic vlan);
        logic [ADDR_W-1:0] l2;
        logic [ADDR_W-1:0] u;
        logic [ADDR_W-1:0] j;
        logic [ADDR_W-1:0] k;
        t_map              m;
        l2 = vlan ? L2_VLAN : L2_PLAIN;
        u = l2 + IP_LEN;
        j = idx - l2;
        k = idx - u;
        m.addr = idx;
        m.sel = SEL_STORE;
        if (idx < 6'd6) begin
            m.addr = idx + 6'd6;
        end else if (idx < 6'd12) begin
            m.addr = idx - 6'd6;
        end else if (idx < l2) begin
            m.addr = idx;
        end else if (idx < u) begin
            if (j == 6'd10 || j == 6'd11) begin
                m.sel = SEL_ZERO;
            end else if (j >= 6'd12 && j < 6'd16) begin
                m.addr = idx + 6'd4;
            end else if (j >= 6'd16) begin
                m.addr = idx - 6'd4;
            end
        end else begin
            if (k < 6'd2) begin
                m.addr = idx + 6'd2;
            end else if (k < 6'd4) begin
                m.addr = idx - 6'd2;
            end else if (k == 6'd6) begin
                m.sel = SEL_CSUM_HI;
            end else if (k == 6'd7) begin
                m.sel = SEL_CSUM_LO;
            end
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/uehr_hdr_mem.sv
// Header store: single write port, single registered read port.
module uehr_hdr_mem (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [uehr_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic                         i_re,
    input  logic [uehr_pkg::ADDR_W-1:0]  i_raddr,
    output logic [7:0]                   o_rdata
);
    import uehr_pkg::*;

    logic [7:0] r_mem [HDR_DEPTH];
    logic [7:0] r_q;

    // Write collected bytes
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold data when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/uehr_csum.sv
// Running pseudo-header sum, built as the IPv4 header bytes are collected.
module uehr_csum (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [uehr_pkg::ADDR_W-1:0]  i_pos,
    input  logic                         i_vlan,
    input  logic [7:0]                   i_byte,
    output logic [15:0]                  o_csum
);
    import uehr_pkg::*;

    logic [18:0]       r_acc;
    logic [3:0]        r_ihl;
    logic [7:0]        r_tlen_hi;
    logic [ADDR_W-1:0] l2;
    logic [ADDR_W-1:0] rel;
    logic              in_ip;
    logic [15:0]       udp_len;
    logic [16:0]       fold1;
    logic [15:0]       fold2;

    assign l2 = i_vlan ? L2_VLAN : L2_PLAIN;
    assign rel = i_pos - l2;
    assign in_ip = (i_pos >= l2) && (rel < IP_LEN);
    assign udp_len = {r_tlen_hi, i_byte} - {10'd0, r_ihl, 2'b00};

    // Accumulate protocol, length and both addresses
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_pos == '0) begin
                r_acc <= 19'(PROTO_UDP);
            end else if (in_ip) begin
                if (rel == 6'd0) begin
                    r_ihl <= i_byte[3:0];
                end else if (rel == 6'd2) begin
                    r_tlen_hi <= i_byte;
                end else if (rel == 6'd3) begin
                    r_acc <= r_acc + {3'd0, udp_len};
                end else if (rel >= 6'd12) begin
                    if (rel[0]) begin
                        r_acc <= r_acc + {11'd0, i_byte};
                    end else begin
                        r_acc <= r_acc + {3'd0, i_byte, 8'd0};
                    end
                end
            end
        end
    end

    // Fold carries back twice; the second fold cannot carry out again
    assign fold1 = {1'b0, r_acc[15:0]} + {14'd0, r_acc[18:16]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
    assign o_csum = fold2;

endmodule

>>> hw/rtl/udp_echo_header_rewriter.sv
// Top level: frame parser, header flush sequencer and output register.
// Bytes enter one per cycle, when the input is not stalled, while the header
// (42 bytes, or 46 with one 802.1Q tag) is collected into the header store.
// After the final UDP header byte the input is stalled while the rewritten
// header leaves at one byte per cycle unless the output stalls, read back
// through the store's single registered read port. Payload bytes then pass
// through at one byte per cycle while the output does not stall. Frames
// that are not IPv4/UDP or end inside the header produce no output.
module udp_echo_header_rewriter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_first,
    output logic       o_out_last
);
    import uehr_pkg::*;

    // Parser state
    logic [1:0]        r_mode, n_mode;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic              r_vlan, n_vlan;
    logic [7:0]        r_prev, n_prev;

    // Flush sequencer
    logic              r_flush, n_flush;
    logic [ADDR_W-1:0] r_fidx, n_fidx;
    logic [ADDR_W-1:0] r_fend, n_fend;
    logic              r_flast, n_flast;
    logic              r_fvlan, n_fvlan;

    // Read stage
    logic              r_rd_valid, n_rd_valid;
    logic [1:0]        r_rd_sel, n_rd_sel;
    logic              r_rd_first, n_rd_first;
    logic              r_rd_last, n_rd_last;

    // Output register
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_obyte, n_obyte;
    logic              r_ofirst, n_ofirst;
    logic              r_olast, n_olast;

    logic              in_acc;
    logic              col_acc;
    logic              out_load;
    logic              rd_issue;
    logic [ADDR_W-1:0] l2;
    logic [ADDR_W-1:0] hdr_end;
    logic [15:0]       etype;
    logic              drop;
    logic              hdr_done;
    t_map              fmap;
    logic [7:0]        mem_q;
    logic [15:0]       csum;
    logic [7:0]        rd_byte;

    // Hold input while the header drains or the payload path is blocked
    assign o_in_stall = r_flush || r_rd_valid || (r_mode == MODE_PASS && r_ovalid && i_out_stall);
    assign in_acc = i_in_valid && !o_in_stall;
    assign col_acc = in_acc && (r_mode == MODE_COLLECT);
    assign out_load = !r_ovalid || !i_out_stall;
    assign rd_issue = r_flush && (!r_rd_valid || out_load);

    // Header checks
    assign l2 = r_vlan ? L2_VLAN : L2_PLAIN;
    assign hdr_end = r_vlan ? HDR_END_VLAN : HDR_END_PLAIN;
    assign etype = {r_prev, i_in_byte};
    assign drop = (r_pos == ETYPE_LO_POS && etype != ETYPE_VLAN && etype != ETYPE_IPV4)
               || (r_vlan && r_pos == INNER_LO_POS && etype != ETYPE_IPV4)
               || (r_pos == l2 + PROTO_OFS && i_in_byte != PROTO_UDP);
    assign hdr_done = !drop && (r_pos == hdr_end);

    assign fmap = hdr_map(r_fidx, r_fvlan);

    uehr_hdr_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (col_acc),
        .i_waddr (r_pos),
        .i_wdata (i_in_byte),
        .i_re    (rd_issue),
        .i_raddr (fmap.addr),
        .o_rdata (mem_q)
    );

    uehr_csum u_csum (
        .i_clk  (i_clk),
        .i_en   (col_acc),
        .i_pos  (r_pos),
        .i_vlan (r_vlan),
        .i_byte (i_in_byte),
        .o_csum (csum)
    );

    // Pick the rewritten byte from the read stage
    always_comb begin
        case (r_rd_sel)
            SEL_STORE:   rd_byte = mem_q;
            SEL_ZERO:    rd_byte = 8'd0;
            SEL_CSUM_HI: rd_byte = csum[15:8];
            SEL_CSUM_LO: rd_byte = csum[7:0];
            default:     rd_byte = mem_q;
        endcase
    end

    // Next-state logic
    always_comb begin
        n_mode = r_mode;
        n_pos = r_pos;
        n_vlan = r_vlan;
        n_prev = r_prev;
        n_flush = r_flush;
        n_fidx = r_fidx;
        n_fend = r_fend;
        n_flast = r_flast;
        n_fvlan = r_fvlan;
        n_rd_valid = r_rd_valid;
        n_rd_sel = r_rd_sel;
        n_rd_first = r_rd_first;
        n_rd_last = r_rd_last;
        n_ovalid = r_ovalid;
        n_obyte = r_obyte;
        n_ofirst = r_ofirst;
        n_olast = r_olast;

        // Parse the incoming word
        case (r_mode)
            MODE_COLLECT: begin
                if (in_acc) begin
                    n_prev = i_in_byte;
                    if (r_pos == ETYPE_LO_POS && etype == ETYPE_VLAN) begin
                        n_vlan = 1'b1;
                    end
                    if (drop) begin
                        n_mode = i_in_last ? MODE_COLLECT : MODE_DISCARD;
                        n_pos = '0;
                        n_vlan = 1'b0;
                    end else if (hdr_done) begin
                        n_mode = i_in_last ? MODE_COLLECT : MODE_PASS;
                        n_pos = '0;
                        n_vlan = 1'b0;
                        n_flush = 1'b1;
                        n_fidx = '0;
                        n_fend = hdr_end;
                        n_flast = i_in_last;
                        n_fvlan = r_vlan;
                    end else if (i_in_last) begin
                        n_pos = '0;
                        n_vlan = 1'b0;
                    end else begin
                        n_pos = r_pos + 6'd1;
                    end
                end
            end
            MODE_PASS: begin
                if (in_acc && i_in_last) begin
                    n_mode = MODE_COLLECT;
                end
            end
            default: begin
                if (in_acc && i_in_last) begin
                    n_mode = MODE_COLLECT;
                end
            end
        endcase

        // Advance the header flush through the read stage
        if (rd_issue) begin
            n_rd_valid = 1'b1;
            n_rd_sel = fmap.sel;
            n_rd_first = (r_fidx == '0);
            n_rd_last = r_flast && (r_fidx == r_fend);
            n_fidx = r_fidx + 6'd1;
            if (r_fidx == r_fend) begin
                n_flush = 1'b0;
            end
        end else if (out_load) begin
            n_rd_valid = 1'b0;
        end

        // Load the output register
        if (out_load) begin
            if (r_rd_valid) begin
                n_ovalid = 1'b1;
                n_obyte = rd_byte;
                n_ofirst = r_rd_first;
                n_olast = r_rd_last;
            end else if (in_acc && r_mode == MODE_PASS) begin
                n_ovalid = 1'b1;
                n_obyte = i_in_byte;
                n_ofirst = 1'b0;
                n_olast = i_in_last;
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COLLECT;
            r_pos <= '0;
            r_vlan <= 1'b0;
            r_flush <= 1'b0;
            r_rd_valid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pos <= n_pos;
            r_vlan <= n_vlan;
            r_flush <= n_flush;
            r_rd_valid <= n_rd_valid;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload and sequencer registers
    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_fidx <= n_fidx;
        r_fend <= n_fend;
        r_flast <= n_flast;
        r_fvlan <= n_fvlan;
        r_rd_sel <= n_rd_sel;
        r_rd_first <= n_rd_first;
        r_rd_last <= n_rd_last;
        r_obyte <= n_obyte;
        r_ofirst <= n_ofirst;
        r_olast <= n_olast;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_out_first = r_ofirst;
    assign o_out_last = r_olast;

    // A completed header always starts a flush
    a_done_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (col_acc && hdr_done) |=> r_flush)
        else $error("header completed without starting a flush");

    // The flush index never runs past the header end
    a_fidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_fidx <= r_fend))
        else $error("flush index beyond header end");

    // A frame being flushed is never one being discarded
    a_flush_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush || r_rd_valid) |-> (r_mode == MODE_COLLECT || r_mode == MODE_PASS))
        else $error("flush active while discarding");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the UDP echo header rewriter.
module tb;
    import uehr_pkg::*;

    localparam int unsigned MAC_LEN      = 6;
    localparam int unsigned UDP_LEN      = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned LIMIT_CYCLES = 20_000;
    localparam int unsigned IDLE_PCT     = 32;

    // Byte fill patterns for generated frames
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       eof;
    } t_echo_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_first;
    logic       o_out_last;

    // Predictor state
    logic [7:0]  hdr_mem [HDR_DEPTH];
    int unsigned hdr_pos = 0;
    logic [1:0]  rx_mode = MODE_COLLECT;
    bit          tag_seen = 1'b0;

    t_echo_word  echo_q[$];
    logic [7:0]  frame_buf[$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned in_idle_pct = IDLE_PCT;
    int unsigned out_idle_pct = IDLE_PCT;
    bit          hold_req = 1'b0;

    udp_echo_header_rewriter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_first (o_out_first),
        .o_out_last  (o_out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Echo predictor
    // ---------------------------------------------------------------
    function automatic logic [15:0] hdr_word(int unsigned i);
        return {hdr_mem[i], hdr_mem[i + 1]};
    endfunction

    // Fold the pseudo-header words into a one's-complement sum
    function automatic logic [15:0] pseudo_hdr_sum(int unsigned l2);
        logic [15:0] udp_len;
        logic [31:0] acc;
        udp_len = hdr_word(l2 + 2) - {hdr_mem[l2][3:0], 2'b00};
        acc = hdr_word(l2 + 12);
        acc += hdr_word(l2 + 14);
        acc += hdr_word(l2 + 16);
        acc += hdr_word(l2 + 18);
        acc += PROTO_UDP;
        acc += udp_len;
        acc = acc[15:0] + acc[31:16];
        acc = acc[15:0] + acc[31:16];
        return acc[15:0];
    endfunction

    // Pick the rewritten header byte at output index i
    function automatic logic [7:0] echo_hdr_byte(int unsigned i, int unsigned l2,
                                                 logic [15:0] csum);
        int unsigned u;
        int unsigned j;
        int unsigned k;
        u = l2 + IP_LEN;
        if (i < MAC_LEN) return hdr_mem[i + MAC_LEN];
        if (i < 2 * MAC_LEN) return hdr_mem[i - MAC_LEN];
        if (i < l2) return hdr_mem[i];
        if (i < u) begin
            j = i - l2;
            if (j == 10 || j == 11) return 8'h00;
            if (j >= 12 && j < 16) return hdr_mem[i + 4];
            if (j >= 16) return hdr_mem[i - 4];
            return hdr_mem[i];
        end
        k = i - u;
        if (k < 2) return hdr_mem[i + 2];
        if (k < 4) return hdr_mem[i - 2];
        if (k == 6) return csum[15:8];
        if (k == 7) return csum[7:0];
        return hdr_mem[i];
    endfunction

    // Advance the predictor by one accepted word and queue the echoed words
    function automatic void predict_echo(logic [7:0] b, logic eof);
        int unsigned p;
        int unsigned l2;
        int unsigned n;
        int unsigned i;
        bit          ok;
        logic [15:0] csum;
        t_echo_word  w;
        if (rx_mode == MODE_PASS) begin
            w.data = b;
            w.sof = 1'b0;
            w.eof = eof;
            echo_q.push_back(w);
            if (eof) rx_mode = MODE_COLLECT;
            return;
        end
        if (rx_mode != MODE_COLLECT) begin
            if (eof) rx_mode = MODE_COLLECT;
            return;
        end

        p = (hdr_pos >= HDR_DEPTH) ? HDR_DEPTH - 1 : hdr_pos;
        hdr_mem[p] = b;
        ok = 1'b1;
        if (p == ETYPE_LO_POS) begin
            if (hdr_word(ETYPE_LO_POS - 1) == ETYPE_VLAN) tag_seen = 1'b1;
            else if (hdr_word(ETYPE_LO_POS - 1) != ETYPE_IPV4) ok = 1'b0;
        end
        if (tag_seen && p == INNER_LO_POS && hdr_word(INNER_LO_POS - 1) != ETYPE_IPV4)
            ok = 1'b0;
        l2 = tag_seen ? L2_VLAN : L2_PLAIN;
        if (p == l2 + PROTO_OFS && b != PROTO_UDP) ok = 1'b0;

        // Drop the frame on a bad ethertype or protocol
        if (!ok) begin
            rx_mode = eof ? MODE_COLLECT : MODE_DISCARD;
            hdr_pos = 0;
            tag_seen = 1'b0;
            return;
        end

        // Flush the rewritten header on its final byte
        n = l2 + IP_LEN + UDP_LEN;
        if (p == n - 1) begin
            csum = pseudo_hdr_sum(l2);
            for (i = 0; i < n; i++) begin
                w.data = echo_hdr_byte(i, l2, csum);
                w.sof = (i == 0);
                w.eof = eof && (i == n - 1);
                echo_q.push_back(w);
            end
            rx_mode = eof ? MODE_COLLECT : MODE_PASS;
            hdr_pos = 0;
            tag_seen = 1'b0;
            return;
        end

        // Short frame: restart collection
        if (eof) begin
            rx_mode = MODE_COLLECT;
            hdr_pos = 0;
            tag_seen = 1'b0;
            return;
        end
        hdr_pos = p + 1;
    endfunction

    // ---------------------------------------------------------------
    // Frame generation
    // ---------------------------------------------------------------
    function automatic logic [7:0] fill_byte(int kind);
        case (kind)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_frame(bit with_tag, logic [15:0] etype, logic [7:0] proto,
                                        int unsigned payload_len, int kind);
        int unsigned i;
        frame_buf.delete();
        for (i = 0; i < 2 * MAC_LEN; i++) frame_buf.push_back(fill_byte(kind));
        if (with_tag) begin
            frame_buf.push_back(ETYPE_VLAN[15:8]);
            frame_buf.push_back(ETYPE_VLAN[7:0]);
            frame_buf.push_back(fill_byte(kind));
            frame_buf.push_back(fill_byte(kind));
        end
        frame_buf.push_back(etype[15:8]);
        frame_buf.push_back(etype[7:0]);
        for (i = 0; i < IP_LEN; i++)
            frame_buf.push_back((i == PROTO_OFS) ? proto : fill_byte(kind));
        for (i = 0; i < UDP_LEN + payload_len; i++) frame_buf.push_back(fill_byte(kind));
    endfunction

    // Cut the frame short so that its last mark lands early
    function automatic void trim_frame(int unsigned len);
        while (frame_buf.size() > len) void'(frame_buf.pop_back());
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_word(logic [7:0] b, logic eof);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= eof;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_echo(b, eof);
    endtask

    task automatic send_frame();
        int unsigned i;
        for (i = 0; i < frame_buf.size(); i++)
            send_word(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic wait_drained();
        while (echo_q.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Output side: random stalls, with a long hold-off on request
    // ---------------------------------------------------------------
    initial begin : out_side
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // Compare each accepted output word with the oldest expected one
    always @(posedge i_clk) begin
        t_echo_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (echo_q.size() == 0) begin
                $display("%0t: unexpected word byte=%02h first=%b last=%b",
                         $time, o_out_byte, o_out_first, o_out_last);
                mismatch_cnt++;
            end else begin
                want = echo_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, want.data, o_out_byte);
                    mismatch_cnt++;
                end
                if (o_out_first !== want.sof) begin
                    $display("%0t: out_first expected %b got %b",
                             $time, want.sof, o_out_first);
                    mismatch_cnt++;
                end
                if (o_out_last !== want.eof) begin
                    $display("%0t: out_last expected %b got %b",
                             $time, want.eof, o_out_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("udp_echo_header_rewriter verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Echo a plain frame with a short payload
    task automatic test_echo_basic();
        build_frame(1'b0, ETYPE_IPV4, PROTO_UDP, 3, FILL_RANDOM);
        send_frame();
    endtask

    // Pause the input until every echoed word is out
    task automatic test_drain_pause();
        i_in_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
    endtask

    // Push an all-one tagged header through the checksum fold, last mark on the header end
    task automatic test_field_extremes();
        build_frame(1'b1, ETYPE_IPV4, PROTO_UDP, 0, FILL_ONES);
        send_frame();
    endtask

    // Drop frames with a bad type, bad protocol, a double tag, or an early end
    task automatic test_drop_frames();
        build_frame(1'b0, ETYPE_IPV6, PROTO_UDP, 0, FILL_RANDOM);
        trim_frame(ETYPE_LO_POS + 3);
        send_frame();
        build_frame(1'b0, ETYPE_IPV4, PROTO_TCP, 0, FILL_RANDOM);
        trim_frame(L2_PLAIN + PROTO_OFS + 3);
        send_frame();
        build_frame(1'b1, ETYPE_VLAN, PROTO_UDP, 0, FILL_RANDOM);
        trim_frame(INNER_LO_POS + 3);
        send_frame();
        build_frame(1'b0, ETYPE_IPV4, PROTO_UDP, 0, FILL_RANDOM);
        trim_frame(3);
        send_frame();
    endtask

    // Run a frame with no idling on either side; also checks restart after drops
    task automatic test_full_rate();
        in_idle_pct = 0;
        out_idle_pct = 0;
        build_frame(1'b0, ETYPE_IPV4, PROTO_UDP, 2, FILL_RANDOM);
        send_frame();
        in_idle_pct = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    // Hold off the output long enough to back up into the input
    task automatic test_output_holdoff();
        hold_req = 1'b1;
        build_frame(1'b0, ETYPE_IPV4, PROTO_UDP, 4, FILL_ZERO);
        send_frame();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_echo_basic();
        test_drain_pause();
        test_field_extremes();
        test_drop_frames();
        test_full_rate();
        test_output_holdoff();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && echo_q.size() == 0) begin
            $display("udp_echo_header_rewriter verification clean");
        end else begin
            $display("udp_echo_header_rewriter verification failed");
        end
        $finish;
    end

endmodule
